@@ rtl/core/brsd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brsd_pkg
// Shared constants, command codes and status bundle for the RMS silence
// detector.
// ----------------------------------------------------------------------------
package brsd_pkg;

  localparam int MAX_BLOCK = 4096;
  localparam int BCOUNT_W  = $clog2(MAX_BLOCK + 1);
  localparam int ENERGY_W  = 30 + BCOUNT_W;

  localparam int DIVD_W = 49;
  localparam int DIVS_W = 17;

  localparam logic [33:0] FLOOR_Q31 = 34'd2147484;
  localparam logic [15:0] COEF_0P98 = 16'd64225;
  localparam logic [10:0] COEF_0P02 = 11'd1311;
  localparam logic [11:0] COEF_0P05 = 12'd3277;

  localparam logic [16:0] ACT_MAX   = 17'h1FFFF;
  localparam logic [23:0] QUIET_MAX = 24'hFFFFFF;
  localparam logic [32:0] SUM_MAX   = 33'h1FFFFFFFF;

  localparam logic [1:0] REG_INIT_SAMPLES     = 2'd0;
  localparam logic [1:0] REG_ACTIVITY_SAMPLES = 2'd1;
  localparam logic [1:0] REG_SILENCE_SAMPLES  = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACC,
    OP_DIV_MEAN,
    OP_SQRT_START,
    OP_SQRT_STEP,
    OP_TOTAL,
    OP_MUL_INIT,
    OP_NACC,
    OP_DIV_NOISE,
    OP_NOISE_WR,
    OP_SMOOTH_MUL,
    OP_SMOOTH_WR,
    OP_ACTIVE,
    OP_DIV_REF,
    OP_REF_WR,
    OP_TRACK
  } op_t;

  typedef struct packed {
    logic close;
    logic stopped;
    logic in_end;
    logic div_done;
    logic sqrt_last;
    logic in_init;
    logic detected;
    logic above;
    logic act_done;
  } status_t;

  typedef struct packed {
    op_t  op;
    logic emit;
  } cmd_t;

endpackage
`default_nettype wire

@@ rtl/core/block_rms_silence_detector.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// block_rms_silence_detector
// Energy-based activity and end-of-signal detector over PCM blocks.
// ----------------------------------------------------------------------------
// A sample that does not close a block is accumulated without a stall.
// A closing sample runs a 49-step divide for the block mean, 16 root steps
// and the level update; a second 49-step divide forms the reference level
// and the initial noise average. After stop a block-end sample goes
// straight to the output word. Input stalls from a block close until the
// result word is registered, also while the previous word waits for the sink.
// Synchronous reset clears the tracking state and loads register defaults.
module block_rms_silence_detector (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_wr_en,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [23:0]        cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] pcm_sample,
  input  wire logic               block_end,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    stop,
  output logic                    signal_found,
  output logic [15:0]             block_level,
  output logic [15:0]             noise_level
);
  import brsd_pkg::*;

  cmd_t    cmd;
  status_t st;

  brsd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  brsd_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .pcm_sample   (pcm_sample),
    .block_end    (block_end),
    .stop         (stop),
    .signal_found (signal_found),
    .block_level  (block_level),
    .noise_level  (noise_level)
  );

endmodule
`default_nettype wire

@@ rtl/core/brsd_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brsd_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module brsd_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [brsd_pkg::DIVD_W-1:0]   dividend,
  input  wire logic [brsd_pkg::DIVS_W-1:0]   divisor,
  output logic                               done,
  output logic [brsd_pkg::DIVD_W-1:0]        quotient
);
  import brsd_pkg::*;

  localparam int DCNT_W = $clog2(DIVD_W);

  logic              busy;
  logic [DIVS_W-1:0] rem;
  logic [DIVS_W-1:0] dvs;
  logic [DCNT_W-1:0] cnt;
  logic [DIVS_W:0]   trial;
  logic              ge;
  logic [DIVS_W-1:0] rem_next;

  always_comb begin
    trial    = {rem, quotient[DIVD_W-1]};
    ge       = trial >= {1'b0, dvs};
    rem_next = ge ? DIVS_W'(trial - {1'b0, dvs}) : trial[DIVS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      dvs      <= divisor;
      rem      <= '0;
      cnt      <= DCNT_W'(DIVD_W - 1);
    end else if (busy) begin
      rem      <= rem_next;
      quotient <= {quotient[DIVD_W-2:0], ge};
      cnt      <= cnt - 1'b1;
    end
  end

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("divider done without a run");
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    busy && !start |-> rem < dvs || $past(start)) else $error("remainder overrun");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held");

endmodule
`default_nettype wire

@@ rtl/core/brsd_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brsd_dp
// Datapath: energy accumulation, mean and root, noise tracking, activity and
// silence counters, output word register.
// ----------------------------------------------------------------------------
module brsd_dp (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire brsd_pkg::cmd_t     cmd,
  output brsd_pkg::status_t       st,
  input  wire logic               cfg_wr_en,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [23:0]        cfg_wdata,
  input  wire logic signed [15:0] pcm_sample,
  input  wire logic               block_end,
  output logic                    stop,
  output logic                    signal_found,
  output logic [15:0]             block_level,
  output logic [15:0]             noise_level
);
  import brsd_pkg::*;

  logic [15:0]         init_samples;
  logic [15:0]         activity_samples;
  logic [23:0]         silence_samples;

  logic [ENERGY_W-1:0] energy;
  logic [BCOUNT_W-1:0] bcount;
  logic [BCOUNT_W-1:0] nreg;
  logic [31:0]         total;
  logic [31:0]         prev;
  logic [31:0]         noise;
  logic                detected;
  logic [16:0]         active;
  logic [32:0]         asum;
  logic [15:0]         ref_level;
  logic [23:0]         quiet;
  logic [16:0]         resume;
  logic                stopped;
  logic [15:0]         rms;
  logic [33:0]         thr;
  logic [48:0]         prod;

  logic [30:0]         sq_v;
  logic [31:0]         sq_res;
  logic [3:0]          sq_k;

  logic [BCOUNT_W-1:0] bcount_inc;
  logic [31:0]         sample_sq;
  logic [31:0]         sq_bit;
  logic [31:0]         sq_sum;
  logic                sq_take;
  logic [31:0]         sq_res_next;
  logic [32:0]         total_sum;
  logic [33:0]         noise_x2p5;
  logic [27:0]         ref_thr;
  logic [33:0]         thr_next;
  logic [33:0]         lvl;
  logic [16+BCOUNT_W-1:0] rms_n;
  logic [17:0]         active_sum;
  logic [33:0]         asum_add;
  logic [24:0]         quiet_sum;
  logic [23:0]         quiet_sat;
  logic [17:0]         resume_sum;
  logic [16:0]         resume_sat;
  logic [26:0]         rms_coef;

  logic                div_start;
  logic [DIVD_W-1:0]   div_dividend;
  logic [DIVS_W-1:0]   div_divisor;
  logic                div_done;
  logic [DIVD_W-1:0]   div_quotient;

  always_comb begin
    bcount_inc  = bcount + 1'b1;
    sample_sq   = $unsigned(32'(pcm_sample) * 32'(pcm_sample));
    sq_bit      = 32'd1 << {sq_k, 1'b0};
    sq_sum      = sq_res + sq_bit;
    sq_take     = {1'b0, sq_v} >= sq_sum;
    sq_res_next = sq_take ? (sq_res >> 1) + sq_bit : sq_res >> 1;
    total_sum   = {1'b0, total} + 33'(nreg);
    noise_x2p5  = 34'(({2'b0, noise} * 34'd5) >> 1);
    ref_thr     = ref_level * COEF_0P05;
    thr_next    = noise_x2p5 < FLOOR_Q31 ? FLOOR_Q31 : noise_x2p5;
    if (detected && 34'(ref_thr) > thr_next) begin
      thr_next = 34'(ref_thr);
    end
    lvl         = {2'b0, rms, 16'b0};
    rms_n       = rms * nreg;
    active_sum  = {1'b0, active} + 18'(nreg);
    asum_add    = {1'b0, asum} + 34'(rms_n);
    quiet_sum   = {1'b0, quiet} + 25'(nreg);
    quiet_sat   = quiet_sum[24] ? QUIET_MAX : quiet_sum[23:0];
    resume_sum  = {1'b0, resume} + 18'(nreg);
    resume_sat  = resume_sum[17] ? ACT_MAX : resume_sum[16:0];
    rms_coef    = rms * COEF_0P02;
  end

  always_comb begin
    div_start    = 1'b0;
    div_dividend = DIVD_W'(energy);
    div_divisor  = DIVS_W'(bcount);
    case (cmd.op)
      OP_DIV_MEAN: begin
        div_start = 1'b1;
      end
      OP_DIV_NOISE: begin
        div_start    = 1'b1;
        div_dividend = prod;
        div_divisor  = total[DIVS_W-1:0];
      end
      OP_DIV_REF: begin
        div_start    = 1'b1;
        div_dividend = DIVD_W'(asum);
        div_divisor  = active;
      end
      default: begin
      end
    endcase
  end

  brsd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  always_comb begin
    st.close     = block_end || bcount_inc == BCOUNT_W'(MAX_BLOCK);
    st.stopped   = stopped;
    st.in_end    = block_end;
    st.div_done  = div_done;
    st.sqrt_last = sq_k == 4'd0;
    st.in_init   = total <= {16'b0, init_samples};
    st.detected  = detected;
    st.above     = lvl > thr;
    st.act_done  = active >= {1'b0, activity_samples};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      init_samples     <= 16'd9600;
      activity_samples <= 16'd9600;
      silence_samples  <= 24'd96000;
      energy           <= '0;
      bcount           <= '0;
      total            <= '0;
      noise            <= '0;
      detected         <= 1'b0;
      active           <= '0;
      asum             <= '0;
      ref_level        <= '0;
      quiet            <= '0;
      resume           <= '0;
      stopped          <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_INIT_SAMPLES:     init_samples     <= cfg_wdata[15:0];
          REG_ACTIVITY_SAMPLES: activity_samples <= cfg_wdata[15:0];
          REG_SILENCE_SAMPLES:  silence_samples  <= cfg_wdata;
          default: begin
          end
        endcase
      end
      case (cmd.op)
        OP_ACC: begin
          if (!stopped) begin
            energy <= energy + ENERGY_W'(sample_sq);
            bcount <= bcount_inc;
          end
        end
        OP_DIV_MEAN: begin
          energy <= '0;
          bcount <= '0;
        end
        OP_TOTAL: begin
          total <= total_sum[32] ? 32'hFFFFFFFF : total_sum[31:0];
        end
        OP_NOISE_WR: begin
          noise <= div_quotient[31:0];
        end
        OP_SMOOTH_WR: begin
          noise  <= prod[47:16] + 32'(rms_coef);
          active <= '0;
          asum   <= '0;
        end
        OP_ACTIVE: begin
          active <= active_sum[17] ? ACT_MAX : active_sum[16:0];
          asum   <= asum_add > {1'b0, SUM_MAX} ? SUM_MAX : asum_add[32:0];
        end
        OP_REF_WR: begin
          detected  <= 1'b1;
          ref_level <= div_quotient[15:0];
          quiet     <= '0;
        end
        OP_TRACK: begin
          if (lvl < thr) begin
            quiet   <= quiet_sat;
            resume  <= '0;
            stopped <= quiet_sat >= silence_samples;
          end else if (resume_sat >= {1'b0, activity_samples}) begin
            quiet  <= '0;
            resume <= {1'b0, activity_samples};
          end else begin
            resume <= resume_sat;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_ACC: begin
        if (stopped) begin
          rms <= '0;
        end
      end
      OP_DIV_MEAN: begin
        nreg <= bcount;
      end
      OP_SQRT_START: begin
        sq_v   <= div_quotient[30:0];
        sq_res <= '0;
        sq_k   <= 4'd15;
      end
      OP_SQRT_STEP: begin
        if (sq_take) begin
          sq_v <= 31'(sq_v - sq_sum);
        end
        sq_res <= sq_res_next;
        sq_k   <= sq_k - 1'b1;
        rms    <= sq_res_next[15:0];
      end
      OP_TOTAL: begin
        prev <= total;
        thr  <= thr_next;
      end
      OP_MUL_INIT: begin
        prod <= 49'(noise * prev[15:0]);
      end
      OP_NACC: begin
        prod <= prod + {1'b0, 32'(rms_n), 16'b0};
      end
      OP_SMOOTH_MUL: begin
        prod <= 49'(noise * COEF_0P98);
      end
      default: begin
      end
    endcase
    if (cmd.emit) begin
      stop         <= stopped;
      signal_found <= detected;
      block_level  <= rms;
      noise_level  <= noise[31:16];
    end
  end

  a_stop_needs_signal: assert property (@(posedge clk) disable iff (rst)
    stopped |-> detected) else $error("stop without signal");
  a_block_bound: assert property (@(posedge clk) disable iff (rst)
    bcount <= BCOUNT_W'(MAX_BLOCK)) else $error("block count overrun");
  a_stopped_holds: assert property (@(posedge clk) disable iff (rst)
    $past(stopped) && !$past(rst) |-> stopped) else $error("stop cleared");

endmodule
`default_nettype wire

@@ rtl/core/brsd_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brsd_ctrl
// Sequencer for the block close: mean, root, noise, activity and silence
// update, output word hand-off.
// ----------------------------------------------------------------------------
module brsd_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  input  wire brsd_pkg::status_t st,
  output brsd_pkg::cmd_t         cmd
);
  import brsd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MEAN_START,
    S_MEAN_WAIT,
    S_SQRT,
    S_TOTAL,
    S_CLASS,
    S_NACC,
    S_NDIV_START,
    S_NDIV_WAIT,
    S_SMOOTH,
    S_ACTCHK,
    S_RDIV_WAIT,
    S_TRACK,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign in_stall = state != S_IDLE;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    cmd.emit   = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = OP_ACC;
          if (st.stopped) begin
            if (st.in_end) begin
              state_next = S_EMIT;
            end
          end else if (st.close) begin
            state_next = S_MEAN_START;
          end
        end
      end
      S_MEAN_START: begin
        cmd.op     = OP_DIV_MEAN;
        state_next = S_MEAN_WAIT;
      end
      S_MEAN_WAIT: begin
        if (st.div_done) begin
          cmd.op     = OP_SQRT_START;
          state_next = S_SQRT;
        end
      end
      S_SQRT: begin
        cmd.op = OP_SQRT_STEP;
        if (st.sqrt_last) begin
          state_next = S_TOTAL;
        end
      end
      S_TOTAL: begin
        cmd.op     = OP_TOTAL;
        state_next = S_CLASS;
      end
      S_CLASS: begin
        if (st.in_init) begin
          cmd.op     = OP_MUL_INIT;
          state_next = S_NACC;
        end else if (st.detected) begin
          state_next = S_TRACK;
        end else if (st.above) begin
          cmd.op     = OP_ACTIVE;
          state_next = S_ACTCHK;
        end else begin
          cmd.op     = OP_SMOOTH_MUL;
          state_next = S_SMOOTH;
        end
      end
      S_NACC: begin
        cmd.op     = OP_NACC;
        state_next = S_NDIV_START;
      end
      S_NDIV_START: begin
        cmd.op     = OP_DIV_NOISE;
        state_next = S_NDIV_WAIT;
      end
      S_NDIV_WAIT: begin
        if (st.div_done) begin
          cmd.op     = OP_NOISE_WR;
          state_next = S_EMIT;
        end
      end
      S_SMOOTH: begin
        cmd.op     = OP_SMOOTH_WR;
        state_next = S_EMIT;
      end
      S_ACTCHK: begin
        if (st.act_done) begin
          cmd.op     = OP_DIV_REF;
          state_next = S_RDIV_WAIT;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_RDIV_WAIT: begin
        if (st.div_done) begin
          cmd.op     = OP_REF_WR;
          state_next = S_EMIT;
        end
      end
      S_TRACK: begin
        cmd.op     = OP_TRACK;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_emit_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> out_free) else $error("output word overwritten");
  a_emit_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_valid) else $error("output word lost");
  a_div_done_waited: assert property (@(posedge clk) disable iff (rst)
    st.div_done |-> state == S_MEAN_WAIT || state == S_NDIV_WAIT
                    || state == S_RDIV_WAIT) else $error("divider result unclaimed");

endmodule
`default_nettype wire
